// ===== src/sle_pkg.sv =====
// Shared types and constants for the sorted list engine.
`default_nettype none

package sle_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_VAL = 2'd1,
        CMD_DEL_MIN = 2'd2,
        CMD_DEL_MAX = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_ctrl;

endpackage

`default_nettype wire

// ===== src/sorted_list_engine_top.sv =====
// Top level of the sorted list engine: controller plus datapath.
//
//   Channel   Direction  Handshake               Payload
//   command   in         i_in_valid/o_in_stall   i_cmd, i_value
//   result    out        o_out_valid/i_out_stall o_status, o_removed_value, o_occupancy
//
// Each command first registers, at its transfer, the parallel compare of the value
// against all entries; the update step then shifts the entry row and loads the
// result register. A result waiting in the output register does not block the
// next command transfer; only the update step waits for the register to drain.
// Reset clears the entry count and the handshake state; entries need no clearing.
`default_nettype none

module sorted_list_engine_top import sle_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [1:0]              i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [1:0]                   o_status,
    output logic signed [VAL_W-1:0]      o_removed_value,
    output logic [CNT_W-1:0]             o_occupancy
);

    t_dp_ctrl dp_ctrl;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_ctrl   (dp_ctrl)
    );

    sle_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_ctrl       (dp_ctrl),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy)
    );

endmodule

`default_nettype wire

// ===== src/sle_ctrl.sv =====
// Controller state machine for the sorted list engine.
`default_nettype none

module sle_ctrl import sle_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_dp_ctrl      o_dp_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid && i_out_stall;
        o_dp_ctrl.load   = 1'b0;
        o_dp_ctrl.exec   = 1'b0;
        o_in_stall       = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_dp_ctrl.load = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                // The table update and the result load happen together, so
                // wait here until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    o_dp_ctrl.exec = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/sle_datapath.sv =====
// Datapath of the sorted list engine: entry row, compare masks and result register.
`default_nettype none

module sle_datapath import sle_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_ctrl                i_dp_ctrl,
    input  wire logic [1:0]              i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic [1:0]                   o_status,
    output logic signed [VAL_W-1:0]      o_removed_value,
    output logic [CNT_W-1:0]             o_occupancy
);

    logic signed [VAL_W-1:0] r_entries [DEPTH];
    logic signed [VAL_W-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    t_cmd                    r_cmd;
    logic signed [VAL_W-1:0] r_value;
    logic [DEPTH-1:0]        r_ins_mask;
    logic [DEPTH-1:0]        r_ge_mask;
    logic                    r_found;

    logic [DEPTH-1:0]        ins_mask;
    logic [DEPTH-1:0]        ge_mask;
    logic [DEPTH-1:0]        eq_mask;

    t_status                 status;
    logic signed [VAL_W-1:0] removed;
    logic [CNT_W-1:0]        last_pos;

    t_status                 r_status;
    logic signed [VAL_W-1:0] r_removed;
    logic [CNT_W-1:0]        r_occ;

    // Parallel compare of the incoming value against every live entry. Since
    // the row is sorted, the insert mask is a suffix of the row and the ge mask
    // one of the live entries, so each marks where a shift starts without a search.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ins_mask[i] = (CNT_W'(i) >= r_count) || (r_entries[i] > i_value);
            ge_mask[i]  = (CNT_W'(i) < r_count) && (r_entries[i] >= i_value);
            eq_mask[i]  = (CNT_W'(i) < r_count) && (r_entries[i] == i_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.load) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_value    <= i_value;
            r_ins_mask <= ins_mask;
            r_ge_mask  <= ge_mask;
            r_found    <= |eq_mask;
        end
    end

    assign last_pos = r_count - CNT_W'(1);

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        status    = ST_OK;
        removed   = '0;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    if (r_ins_mask[0]) begin
                        n_entries[0] = r_value;
                    end
                    for (int i = 1; i < DEPTH; i++) begin
                        if (r_ins_mask[i]) begin
                            n_entries[i] = r_ins_mask[i-1] ? r_entries[i-1] : r_value;
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DEL_VAL: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (!r_found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    // The first equal entry is the first one not below the value.
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (r_ge_mask[i]) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    removed = r_value;
                    n_count = last_pos;
                end
            end
            CMD_DEL_MIN: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_entries[i] = r_entries[i+1];
                    end
                    removed = r_entries[0];
                    n_count = last_pos;
                end
            end
            CMD_DEL_MAX: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    removed = r_entries[last_pos[IDX_W-1:0]];
                    n_count = last_pos;
                end
            end
            default: status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.exec) begin
            r_entries <= n_entries;
            r_status  <= status;
            r_removed <= removed;
            r_occ     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_ctrl.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_occupancy     = r_occ;

endmodule

`default_nettype wire
